/* design/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define GMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gmp assertion failed");

// next-cycle implication, disabled while reset is held
`define GMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gmp assertion failed");

`endif

/* design/gmp_pkg.sv */
`timescale 1ns / 1ps

package gmp_pkg;

    localparam int GMP_MAX_ROWS    = 128;
    localparam int GMP_MAX_COLUMNS = 128;

    localparam int VALUE_W   = 16;
    localparam int PATH_W    = 24;
    localparam int COST_W    = 25;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [COST_W-1:0] COST_SAT  = 25'h0FF_FFFF;
    localparam logic [COST_W-1:0] COST_NONE = 25'h100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT    = 2'd0,
        CFG_COLUMN_COUNT = 2'd1,
        CFG_START_ROW    = 2'd2,
        CFG_START_COLUMN = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CFG_W-1:0] row_count;
        logic [CFG_W-1:0] column_count;
        logic [CFG_W-1:0] start_row;
        logic [CFG_W-1:0] start_column;
    } t_gmp_cfg;

    function automatic logic [COST_W-1:0] cost_min(
        input logic [COST_W-1:0] a,
        input logic [COST_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

/* design/gmp_ifs.sv */
`timescale 1ns / 1ps

interface gmp_cell_if;
    import gmp_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] cell_value;
    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

interface gmp_result_if;
    import gmp_pkg::*;
    logic              valid;
    logic              ready;
    logic [PATH_W-1:0] path_min;
    logic              unreachable;
    modport source (output valid, output path_min, output unreachable, input ready);
    modport sink (input valid, input path_min, input unreachable, output ready);
endinterface

interface gmp_cfg_if;
    import gmp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* design/gmp_cfg_regs.sv */
`timescale 1ns / 1ps

module gmp_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gmp_cfg_if.sink           i_cfg,
    output gmp_pkg::t_gmp_cfg o_cfg
);
    import gmp_pkg::*;

    t_gmp_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count    <= CFG_W'(1);
            r_cfg.column_count <= CFG_W'(1);
            r_cfg.start_row    <= CFG_W'(1);
            r_cfg.start_column <= CFG_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ROW_COUNT:    r_cfg.row_count    <= i_cfg.data;
                CFG_COLUMN_COUNT: r_cfg.column_count <= i_cfg.data;
                CFG_START_ROW:    r_cfg.start_row    <= i_cfg.data;
                CFG_START_COLUMN: r_cfg.start_column <= i_cfg.data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

endmodule

/* design/gmp_cost_mem.sv */
`timescale 1ns / 1ps

module gmp_cost_mem #(
    parameter int DEPTH = gmp_pkg::GMP_MAX_ROWS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [gmp_pkg::COST_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr_a,
    input  logic [AW-1:0]             i_raddr_b,
    output logic [gmp_pkg::COST_W-1:0] o_rdata_a,
    output logic [gmp_pkg::COST_W-1:0] o_rdata_b
);
    import gmp_pkg::*;

    logic [COST_W-1:0] r_mem [DEPTH];
    logic [COST_W-1:0] r_rdata_a;
    logic [COST_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first on an address match
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr_a)) begin
            r_rdata_a <= i_wdata;
        end else begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_we && (i_waddr == i_raddr_b)) begin
            r_rdata_b <= i_wdata;
        end else begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* design/gmp_cell_cost.sv */
`timescale 1ns / 1ps

module gmp_cell_cost (
    input  logic [gmp_pkg::VALUE_W-1:0] i_value,
    input  logic [gmp_pkg::COST_W-1:0]  i_level,
    input  logic [gmp_pkg::COST_W-1:0]  i_up,
    input  logic [gmp_pkg::COST_W-1:0]  i_down,
    input  logic                        i_first,
    input  logic                        i_start_hit,
    output logic [gmp_pkg::COST_W-1:0]  o_cost
);
    import gmp_pkg::*;

    logic [COST_W-1:0] best;
    logic [COST_W-1:0] sum;

    always_comb begin
        best = cost_min(cost_min(i_up, i_level), i_down);
        sum  = best + COST_W'(i_value);
        if (i_first) begin
            o_cost = i_start_hit ? COST_W'(i_value) : COST_NONE;
        end else if (best >= COST_NONE) begin
            o_cost = COST_NONE;
        end else if (sum > COST_SAT) begin
            o_cost = COST_SAT;
        end else begin
            o_cost = sum;
        end
    end

endmodule

/* design/grid_min_path_three_moves_unit.sv */
`timescale 1ns / 1ps

// Least path sum across a grid whose cells stream in column-major order, one
// cell per item; each move steps one column right to the row above, level or
// below. One cell is accepted every cycle, with no bubbles between columns or
// grids; only a grid's last cell stalls, behind an untaken result. The
// previous column's costs live in a one-write, two-read memory of MAX_ROWS
// entries whose reads are addressed from the next row index, with
// write-first forwarding, so the per-cell cost is a three-way minimum, an add
// and a saturate. The result item is registered and appears the cycle after
// the last cell of the grid; cells keep flowing while it waits. The cost
// memory needs no clearing after reset. Configure between grids.
module grid_min_path_three_moves_unit #(
    parameter int MAX_ROWS    = gmp_pkg::GMP_MAX_ROWS,
    parameter int MAX_COLUMNS = gmp_pkg::GMP_MAX_COLUMNS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gmp_cell_if.sink      i_cell,
    gmp_result_if.source  o_result,
    gmp_cfg_if.sink       i_cfg
);
    import gmp_pkg::*;

    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int CLW  = $clog2(MAX_COLUMNS + 1);
    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MW   = (RW > CLW) ? RW : CLW;
    localparam int CMPW = (MW > CFG_W) ? MW : CFG_W;

    t_gmp_cfg cfg;

    logic [RW-1:0]     r_row;
    logic [CLW-1:0]    r_col;
    logic [COST_W-1:0] r_held;
    logic [COST_W-1:0] r_min;
    logic              r_out_valid;
    logic [PATH_W-1:0] r_out_path;
    logic              r_out_unr;

    logic [RW-1:0]     n_row;
    logic [CLW-1:0]    n_col;
    logic [COST_W-1:0] n_held;
    logic [COST_W-1:0] n_min;

    logic [CMPW-1:0]   rows_x;
    logic [CMPW-1:0]   cols_x;
    logic [RW-1:0]     rows_c;
    logic [CLW-1:0]    cols_c;
    logic              last_row;
    logic              last_col;
    logic              grid_end;
    logic              active;
    logic              first_col;
    logic              start_hit;
    logic              down_ok;
    logic              accept;

    logic [COST_W-1:0] level_q;
    logic [COST_W-1:0] down_q;
    logic [COST_W-1:0] up_cost;
    logic [COST_W-1:0] down_cost;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] min_upd;

    gmp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    always_comb begin
        rows_x = CMPW'(cfg.row_count);
        cols_x = CMPW'(cfg.column_count);
        if (rows_x == '0) begin
            rows_c = RW'(1);
        end else if (rows_x > CMPW'(MAX_ROWS)) begin
            rows_c = RW'(MAX_ROWS);
        end else begin
            rows_c = rows_x[RW-1:0];
        end
        if (cols_x == '0) begin
            cols_c = CLW'(1);
        end else if (cols_x > CMPW'(MAX_COLUMNS)) begin
            cols_c = CLW'(MAX_COLUMNS);
        end else begin
            cols_c = cols_x[CLW-1:0];
        end
    end

    assign last_row  = (r_row >= rows_c);
    assign last_col  = (r_col >= cols_c);
    assign grid_end  = last_row && last_col;
    assign active    = (CMPW'(r_col) >= CMPW'(cfg.start_column));
    assign first_col = (CMPW'(r_col) == CMPW'(cfg.start_column));
    assign start_hit = (CMPW'(r_row) == CMPW'(cfg.start_row));
    assign down_ok   = !last_row && (r_row < RW'(MAX_ROWS));

    assign i_cell.ready = i_rst_n && (!r_out_valid || o_result.ready || !grid_end);
    assign accept       = i_cell.valid && i_cell.ready;

    assign up_cost   = (r_row > RW'(1)) ? r_held : COST_NONE;
    assign down_cost = down_ok ? down_q : COST_NONE;

    gmp_cell_cost u_cell_cost (
        .i_value     (i_cell.cell_value),
        .i_level     (level_q),
        .i_up        (up_cost),
        .i_down      (down_cost),
        .i_first     (first_col),
        .i_start_hit (start_hit),
        .o_cost      (cost)
    );

    assign min_upd = (active && last_col) ? cost_min(r_min, cost) : r_min;

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_held = r_held;
        n_min  = r_min;
        if (accept) begin
            n_min = min_upd;
            if (active && !first_col) begin
                n_held = level_q;
            end
            if (grid_end) begin
                n_row  = RW'(1);
                n_col  = CLW'(1);
                n_held = COST_NONE;
                n_min  = COST_NONE;
            end else if (last_row) begin
                n_row  = RW'(1);
                n_col  = r_col + CLW'(1);
                n_held = COST_NONE;
            end else begin
                n_row = r_row + RW'(1);
            end
        end
    end

    // reads look one row ahead: level is this row, down is the row below
    gmp_cost_mem #(
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_cost_mem (
        .i_clk     (i_clk),
        .i_we      (accept && active),
        .i_waddr   (AW'(r_row - RW'(1))),
        .i_wdata   (cost),
        .i_raddr_a (AW'(n_row - RW'(1))),
        .i_raddr_b (AW'(n_row)),
        .o_rdata_a (level_q),
        .o_rdata_b (down_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= RW'(1);
            r_col       <= CLW'(1);
            r_held      <= COST_NONE;
            r_min       <= COST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_held <= n_held;
            r_min  <= n_min;
            if (accept && grid_end) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && grid_end) begin
            r_out_unr  <= (min_upd >= COST_NONE);
            r_out_path <= (min_upd >= COST_NONE) ? '0 : min_upd[PATH_W-1:0];
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.path_min    = r_out_path;
    assign o_result.unreachable = r_out_unr;

endmodule

/* design/gmp_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gmp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cell_valid,
    input logic                        i_cell_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [gmp_pkg::PATH_W-1:0]  i_res_path_min,
    input logic                        i_res_unreachable
);
    import gmp_pkg::*;

    `GMP_ASSERT_IMP(a_unr_zero, i_clk, i_rst_n, i_res_valid && i_res_unreachable, i_res_path_min == '0)
    `GMP_ASSERT_IMP(a_res_after_item, i_clk, i_rst_n, $rose(i_res_valid), $past(i_cell_valid && i_cell_ready))
    `GMP_ASSERT_IMP(a_no_res_after_rst, i_clk, i_rst_n, !$past(i_rst_n), !i_res_valid)
    `GMP_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_path_min) && $stable(i_res_unreachable))

endmodule

bind grid_min_path_three_moves_unit gmp_checker u_gmp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cell_valid      (i_cell.valid),
    .i_cell_ready      (i_cell.ready),
    .i_res_valid       (o_result.valid),
    .i_res_ready       (o_result.ready),
    .i_res_path_min    (o_result.path_min),
    .i_res_unreachable (o_result.unreachable)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gmp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CELLS = 300;

    typedef struct {
        logic [PATH_W-1:0] path_min;
        logic              unreachable;
    } t_path_result;

    typedef enum int {
        TAKE_ALL,
        TAKE_MOST,
        TAKE_FEW,
        TAKE_ALTERNATE
    } t_take_style;

    class t_grid_path_tracker;
        t_gmp_cfg          setting;
        logic [COST_W-1:0] prev_costs [GMP_MAX_ROWS];
        logic [COST_W-1:0] upper_cost;
        logic [COST_W-1:0] best_so_far;
        int                row_at;
        int                col_at;
        t_path_result      pending_minima [$];
        int                failures;

        function new();
            setting.row_count    = 8'd1;
            setting.column_count = 8'd1;
            setting.start_row    = 8'd1;
            setting.start_column = 8'd1;
            foreach (prev_costs[i]) prev_costs[i] = '0;
            upper_cost  = COST_NONE;
            best_so_far = COST_NONE;
            row_at      = 1;
            col_at      = 1;
            failures    = 0;
        endfunction

        function void apply_setting(t_cfg_reg which, logic [CFG_W-1:0] d);
            case (which)
                CFG_ROW_COUNT:    setting.row_count = d;
                CFG_COLUMN_COUNT: setting.column_count = d;
                CFG_START_ROW:    setting.start_row = d;
                CFG_START_COLUMN: setting.start_column = d;
                default: ;
            endcase
        endfunction

        function int clamp_count(logic [CFG_W-1:0] v, int top);
            if (v == 0) return 1;
            return (int'(v) > top) ? top : int'(v);
        endfunction

        function int cells_per_grid();
            return clamp_count(setting.row_count, GMP_MAX_ROWS) *
                   clamp_count(setting.column_count, GMP_MAX_COLUMNS);
        endfunction

        function void take_cell(logic [VALUE_W-1:0] v);
            int                rows;
            int                cols;
            int                idx;
            bit                last_row;
            bit                last_col;
            logic [COST_W-1:0] cost;
            logic [COST_W-1:0] lvl;
            logic [COST_W-1:0] up;
            logic [COST_W-1:0] dn;
            logic [COST_W-1:0] best;
            t_path_result      res;
            rows     = clamp_count(setting.row_count, GMP_MAX_ROWS);
            cols     = clamp_count(setting.column_count, GMP_MAX_COLUMNS);
            idx      = (row_at - 1) % GMP_MAX_ROWS;
            last_row = row_at >= rows;
            last_col = col_at >= cols;
            if (col_at >= int'(setting.start_column)) begin
                if (col_at == int'(setting.start_column)) begin
                    cost = (row_at == int'(setting.start_row)) ? COST_W'(v) : COST_NONE;
                end else begin
                    lvl  = prev_costs[idx];
                    up   = (row_at > 1) ? upper_cost : COST_NONE;
                    dn   = (!last_row && row_at < GMP_MAX_ROWS) ? prev_costs[row_at] : COST_NONE;
                    best = (up < lvl) ? up : lvl;
                    if (dn < best) best = dn;
                    if (best >= COST_NONE) begin
                        cost = COST_NONE;
                    end else begin
                        cost = best + COST_W'(v);
                        if (cost > COST_SAT) cost = COST_SAT;
                    end
                    upper_cost = lvl;
                end
                prev_costs[idx] = cost;
                if (last_col && cost < best_so_far) best_so_far = cost;
            end
            if (last_row && last_col) begin
                res.unreachable = best_so_far >= COST_NONE;
                res.path_min    = res.unreachable ? '0 : best_so_far[PATH_W-1:0];
                pending_minima.push_back(res);
                row_at      = 1;
                col_at      = 1;
                best_so_far = COST_NONE;
                upper_cost  = COST_NONE;
            end else if (last_row) begin
                row_at     = 1;
                col_at     = col_at + 1;
                upper_cost = COST_NONE;
            end else begin
                row_at = row_at + 1;
            end
        endfunction

        function void match_result(logic [PATH_W-1:0] path_min, logic unreachable);
            t_path_result want;
            if (pending_minima.size() == 0) begin
                $error("result item with no grid pending: path_min %0d unreachable %0b",
                       path_min, unreachable);
                failures++;
                return;
            end
            want = pending_minima.pop_front();
            if (path_min !== want.path_min) begin
                $error("path_min expected %0d actual %0d", want.path_min, path_min);
                failures++;
            end
            if (unreachable !== want.unreachable) begin
                $error("unreachable expected %0b actual %0b", want.unreachable, unreachable);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gmp_cell_if   cell_ch ();
    gmp_result_if result_ch ();
    gmp_cfg_if    cfg_ch ();

    t_grid_path_tracker tracker = new();

    int          cycle_count = 0;
    int          burst_left = 0;
    int          cells_sent = 0;
    int          take_left = 0;
    t_take_style take_style = TAKE_ALL;

    grid_min_path_three_moves_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (cell_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cell_ch.valid && cell_ch.ready)
            tracker.take_cell(cell_ch.cell_value);
        if (i_rst_n && result_ch.valid && result_ch.ready)
            tracker.match_result(result_ch.path_min, result_ch.unreachable);
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready)
            tracker.apply_setting(t_cfg_reg'(cfg_ch.index), cfg_ch.data);
    end

    // receiver stalls in stretches of changing style
    always @(negedge i_clk) begin
        if (take_left == 0) begin
            take_style = t_take_style'($urandom_range(0, 3));
            take_left  = $urandom_range(20, 120);
        end
        take_left--;
        case (take_style)
            TAKE_ALL:  result_ch.ready = 1'b1;
            TAKE_MOST: result_ch.ready = ($urandom_range(0, 3) != 0);
            TAKE_FEW:  result_ch.ready = ($urandom_range(0, 5) == 0);
            default:   result_ch.ready = ~result_ch.ready;
        endcase
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_cell(input logic [VALUE_W-1:0] v);
        int idle;
        idle = 0;
        if (burst_left == 0) begin
            idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
        end
        repeat (idle) begin
            @(negedge i_clk);
            cell_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        cell_ch.valid      = 1'b1;
        cell_ch.cell_value = v;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        burst_left--;
        cells_sent++;
    endtask

    task automatic run_grids(input int grids, input bit all_max);
        int n;
        n = tracker.cells_per_grid();
        repeat (grids) begin
            for (int i = 0; i < n; i++)
                send_cell(all_max ? '1 : pick_value());
        end
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        cell_ch.valid = 1'b0;
        while (tracker.pending_minima.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg which, input logic [CFG_W-1:0] d);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = which;
        cfg_ch.data  = d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                             input logic [CFG_W-1:0] srow, input logic [CFG_W-1:0] scol);
        quiesce();
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_START_ROW, srow);
        write_reg(CFG_START_COLUMN, scol);
    endtask

    initial begin
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] srow;
        logic [CFG_W-1:0] scol;
        int               start_count;
        cell_ch.valid      = 1'b0;
        cell_ch.cell_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_ROW_COUNT;
        cfg_ch.data        = '0;
        result_ch.ready    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single-cell grids at the reset settings, both value extremes
        send_cell('0);
        send_cell('1);
        configure(8'd3, 8'd3, 8'd2, 8'd1);
        run_grids(2, 1'b0);
        // zero counts behave as one
        configure(8'd0, 8'd0, 8'd1, 8'd1);
        run_grids(2, 1'b0);
        // start row outside the grid
        configure(8'd3, 8'd4, 8'd0, 8'd1);
        run_grids(1, 1'b0);
        configure(8'd3, 8'd4, 8'd255, 8'd2);
        run_grids(1, 1'b0);
        // start column past the last column
        configure(8'd2, 8'd3, 8'd1, 8'd255);
        run_grids(1, 1'b0);
        // start in the last column
        configure(8'd4, 8'd3, 8'd4, 8'd3);
        run_grids(1, 1'b0);
        // one row, no moves up or down
        configure(8'd1, 8'd5, 8'd1, 8'd2);
        run_grids(1, 1'b0);
        // oversized counts clamp to the maximum
        configure(8'd255, 8'd2, 8'd128, 8'd1);
        run_grids(1, 1'b0);
        configure(8'd1, 8'd255, 8'd1, 8'd1);
        run_grids(1, 1'b1);

        start_count = cells_sent;
        while (cells_sent - start_count < RANDOM_CELLS) begin
            if ($urandom_range(0, 19) == 0) begin
                rows = CFG_W'($urandom_range(100, 128));
                cols = CFG_W'($urandom_range(1, 2));
            end else begin
                rows = CFG_W'($urandom_range(0, 8));
                cols = CFG_W'($urandom_range(0, 8));
            end
            srow = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 255))
                                               : CFG_W'($urandom_range(1, (rows == 0) ? 1 : rows));
            scol = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(1, 255))
                                               : CFG_W'($urandom_range(1, (cols == 0) ? 1 : cols));
            configure(rows, cols, srow, scol);
            run_grids($urandom_range(1, 4), 1'b0);
        end

        quiesce();
        repeat (20) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_minima.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/gmp_pkg.sv
design/gmp_ifs.sv
design/gmp_cfg_regs.sv
design/gmp_cost_mem.sv
design/gmp_cell_cost.sv
design/grid_min_path_three_moves_unit.sv
design/gmp_checker.sv
verif/testbench.sv
